@@ hdl/jse_pkg.sv @@
`timescale 1ns / 1ps
// Package for the JSON string escaper: word types, operation codes,
// character constants and the work descriptor passed from front to back.
// No dependencies.

package jse_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // Characters that the escaper emits or recognizes.
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Depth of the descriptor queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input and result words.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       block_format;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // How the back end expands one descriptor.
    typedef enum logic [1:0] {
        KIND_PLAIN,   // one byte: chr
        KIND_PAIR,    // backslash, then chr
        KIND_UNICODE  // backslash, u, 0, 0, two hex digits of chr
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
    } t_desc;

    // Index of the final output byte for each kind.
    function automatic logic [2:0] last_index(input t_kind kind);
        logic [2:0] idx;
        unique case (kind)
            KIND_PLAIN:   idx = 3'd0;
            KIND_PAIR:    idx = 3'd1;
            KIND_UNICODE: idx = 3'd5;
            default:      idx = 3'd0;
        endcase
        return idx;
    endfunction

    // Uppercase hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'd0, nib};
        end else begin
            ch = CH_UPPER_A + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

@@ hdl/jse_front.sv @@
`timescale 1ns / 1ps
// Front end of the escaper: accepts input words, classifies each one into
// a descriptor and holds the mode register and the block-newline latch.
// Depends on jse_pkg.

module jse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_accept,
    input  jse_pkg::t_in_item i_item,
    output logic              o_desc_valid,
    output jse_pkg::t_desc    o_desc
);
    import jse_pkg::*;

    logic r_multiline_mode;
    logic r_json5_newlines;

    // Mode register and the latch that an open word sets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multiline_mode <= 1'b0;
            r_json5_newlines <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_multiline_mode <= i_cfg_wr_data;
            end
            if (i_accept && i_item.op == OP_OPEN) begin
                r_json5_newlines <= r_multiline_mode & i_item.block_format;
            end
        end
    end

    // Classify the accepted word. The unused op code makes no descriptor.
    always_comb begin
        o_desc_valid = i_accept;
        o_desc.kind  = KIND_PLAIN;
        o_desc.chr   = CH_QUOTE;
        unique case (i_item.op)
            OP_OPEN, OP_CLOSE: begin
                o_desc.kind = KIND_PLAIN;
                o_desc.chr  = CH_QUOTE;
            end
            OP_DATA: begin
                o_desc.kind = KIND_PAIR;
                case (i_item.data_byte)
                    CH_BS:     o_desc.chr = CH_LOW_B;
                    CH_TAB:    o_desc.chr = CH_LOW_T;
                    CH_LF:     o_desc.chr = r_json5_newlines ? CH_LF : CH_LOW_N;
                    CH_FF:     o_desc.chr = CH_LOW_F;
                    CH_CR:     o_desc.chr = CH_LOW_R;
                    CH_QUOTE:  o_desc.chr = CH_QUOTE;
                    CH_BSLASH: o_desc.chr = CH_BSLASH;
                    default: begin
                        o_desc.chr  = i_item.data_byte;
                        o_desc.kind = (i_item.data_byte < CH_SPACE) ? KIND_UNICODE
                                                                    : KIND_PLAIN;
                    end
                endcase
            end
            default: begin
                o_desc_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/jse_queue.sv @@
`timescale 1ns / 1ps
// Short descriptor queue between the front and the back end.
// Show-ahead: the head entry is visible whenever the queue is not empty.
// Depends on jse_pkg.

module jse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  jse_pkg::t_desc i_wr_desc,
    input  logic           i_rd_en,
    output logic           o_not_empty,
    output logic           o_full,
    output jse_pkg::t_desc o_head
);
    import jse_pkg::*;

    t_desc                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_count;

    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head      = r_mem[r_rd_ptr];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // No read from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> o_not_empty)
        else $error("queue read while empty");

    // No write into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !o_full)
        else $error("queue write while full");

endmodule

@@ hdl/jse_back.sv @@
`timescale 1ns / 1ps
// Back end of the escaper: expands each descriptor into one to six output
// bytes and holds them in the output register.
// Depends on jse_pkg.

module jse_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_not_empty,
    input  jse_pkg::t_desc    i_q_head,
    output logic              o_q_rd_en,
    input  logic              i_pop,
    output logic              o_out_valid,
    output jse_pkg::t_out_item o_out_item
);
    import jse_pkg::*;

    logic      r_cur_valid;
    t_desc     r_cur;
    logic [2:0] r_idx;
    logic      r_out_valid;
    t_out_item r_out;

    logic      advance;
    logic      is_last;
    logic      load_cur;
    logic [7:0] cur_byte;

    // One byte leaves the current descriptor when the output register frees up.
    assign advance  = r_cur_valid && (!r_out_valid || i_pop);
    assign is_last  = (r_idx == last_index(r_cur.kind));
    assign load_cur = i_q_not_empty && (!r_cur_valid || (advance && is_last));
    assign o_q_rd_en = load_cur;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Byte selection for the current position in the escape.
    always_comb begin
        cur_byte = r_cur.chr;
        case (r_cur.kind)
            KIND_PLAIN: cur_byte = r_cur.chr;
            KIND_PAIR:  cur_byte = (r_idx == 3'd0) ? CH_BSLASH : r_cur.chr;
            KIND_UNICODE: begin
                case (r_idx)
                    3'd0:    cur_byte = CH_BSLASH;
                    3'd1:    cur_byte = CH_LOW_U;
                    3'd2:    cur_byte = CH_ZERO;
                    3'd3:    cur_byte = CH_ZERO;
                    3'd4:    cur_byte = hex_char(r_cur.chr[7:4]);
                    default: cur_byte = hex_char(r_cur.chr[3:0]);
                endcase
            end
            default: cur_byte = r_cur.chr;
        endcase
    end

    // Current descriptor and position within it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else if (load_cur) begin
            r_cur_valid <= 1'b1;
            r_idx       <= 3'd0;
        end else if (advance) begin
            r_cur_valid <= !is_last;
            r_idx       <= is_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_cur) begin
            r_cur <= i_q_head;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.out_byte    <= cur_byte;
            r_out.last_of_run <= is_last;
        end
    end

    // A non-final byte keeps the descriptor in place for the next one.
    a_stay_mid_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !is_last) |=> (r_cur_valid && r_idx == $past(r_idx) + 3'd1))
        else $error("escape sequence cut short");

    // The position never runs past the end of the current escape.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_idx <= last_index(r_cur.kind)))
        else $error("escape position out of range");

    // An idle back end sits at position zero.
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_valid |-> (r_idx == 3'd0))
        else $error("position nonzero while idle");

endmodule

@@ hdl/json_string_escaper.sv @@
`timescale 1ns / 1ps
// Top level of the JSON string escaper: front classifier, descriptor queue
// and back-end expander. Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
//   channel   | handshake           | word
//   ----------+---------------------+-----------------------------------------
//   input     | push / full         | i_in_item  (op, data_byte, block_format)
//   result    | empty / pop         | o_out_item (out_byte, last_of_run)
//   config    | i_cfg_wr_en         | i_cfg_wr_data (multiline_mode)
//
// A plain byte, quote or open/close word yields one output byte; a two-byte
// escape yields two and a unicode escape six. The back-end expander emits one
// byte per cycle while results are popped; input words enter one per cycle
// while the four-entry descriptor queue has room; full rises when the back
// end is behind. Words pass the queue, current-descriptor and output registers.
// Reset is synchronous and clears the queue, the mode and the newline latch.

module json_string_escaper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  jse_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output jse_pkg::t_out_item  o_out_item
);
    import jse_pkg::*;

    logic  accept;
    logic  desc_valid;
    t_desc desc;
    logic  q_not_empty;
    logic  q_full;
    logic  q_rd_en;
    t_desc q_head;
    logic  out_valid;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    jse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .o_desc_valid  (desc_valid),
        .o_desc        (desc)
    );

    jse_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (desc_valid),
        .i_wr_desc   (desc),
        .i_rd_en     (q_rd_en),
        .o_not_empty (q_not_empty),
        .o_full      (q_full),
        .o_head      (q_head)
    );

    jse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_head      (q_head),
        .o_q_rd_en     (q_rd_en),
        .i_pop         (pop && !empty),
        .o_out_valid   (out_valid),
        .o_out_item    (o_out_item)
    );

endmodule

@@ test/tb_json_string_escaper.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for json_string_escaper: drives input words, predicts
// the escaped byte stream and compares every result word. Depends on jse_pkg.

module tb_json_string_escaper;

    import jse_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_WORDS   = 150;

    // Expected escaped text and the escaper state that shapes it.
    class esc_scoreboard;
        t_out_item text_q[$];
        bit        multiline;
        bit        block_nl;
        int        mismatches;

        function void set_mode(bit m);
            multiline = m;
        endfunction

        function int pending();
            return text_q.size();
        endfunction

        function void add_byte(logic [7:0] b);
            t_out_item it;
            it.out_byte    = b;
            it.last_of_run = 1'b0;
            text_q.push_back(it);
        endfunction

        // Work out the output bytes of one accepted input word.
        function void note_input(t_in_item w);
            string     hexd;
            int        first;
            t_out_item tail;
            hexd  = "0123456789ABCDEF";
            first = text_q.size();
            case (w.op)
                OP_OPEN: begin
                    block_nl = multiline & w.block_format;
                    add_byte(CH_QUOTE);
                end
                OP_CLOSE: begin
                    add_byte(CH_QUOTE);
                end
                OP_DATA: begin
                    case (w.data_byte)
                        CH_BS:     begin add_byte(CH_BSLASH); add_byte(CH_LOW_B); end
                        CH_TAB:    begin add_byte(CH_BSLASH); add_byte(CH_LOW_T); end
                        CH_FF:     begin add_byte(CH_BSLASH); add_byte(CH_LOW_F); end
                        CH_CR:     begin add_byte(CH_BSLASH); add_byte(CH_LOW_R); end
                        CH_QUOTE:  begin add_byte(CH_BSLASH); add_byte(CH_QUOTE); end
                        CH_BSLASH: begin add_byte(CH_BSLASH); add_byte(CH_BSLASH); end
                        CH_LF: begin
                            // Block strings in JSON5 mode emit a backslash and then a raw newline.
                            add_byte(CH_BSLASH);
                            add_byte(block_nl ? CH_LF : CH_LOW_N);
                        end
                        default: begin
                            if (w.data_byte < CH_SPACE) begin
                                add_byte(CH_BSLASH);
                                add_byte(CH_LOW_U);
                                add_byte(CH_ZERO);
                                add_byte(CH_ZERO);
                                add_byte(hexd[w.data_byte[7:4]]);
                                add_byte(hexd[w.data_byte[3:0]]);
                            end else begin
                                add_byte(w.data_byte);
                            end
                        end
                    endcase
                end
                default: ;
            endcase
            // Flag the final byte of this word.
            if (text_q.size() > first) begin
                tail = text_q.pop_back();
                tail.last_of_run = 1'b1;
                text_q.push_back(tail);
            end
        endfunction

        // Compare one accepted result word with the oldest expected byte.
        function void check_result(t_out_item got);
            t_out_item want;
            if (text_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: byte %02h last %0b",
                             got.out_byte, got.last_of_run);
                mismatches++;
                return;
            end
            want = text_q.pop_front();
            if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run) begin
                if (mismatches < 10)
                    $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                             want.out_byte, want.last_of_run,
                             got.out_byte, got.last_of_run);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_wr_en;
    logic      i_cfg_wr_data;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    esc_scoreboard sb;
    bit gaps_on;
    int words_sent;
    int cycles;

    json_string_escaper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_in_item     (i_in_item),
        .empty         (empty),
        .pop           (pop),
        .o_out_item    (o_out_item)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the cycle count.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note_input(i_in_item);
            if (pop && !empty)
                sb.check_result(o_out_item);
        end
    end

    // Result side: pop, with random stall bursts while gaps are enabled.
    initial begin
        int stall;
        stall = 0;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop = 1'b0;
                stall--;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                stall = $urandom_range(1, 14) - 1;
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Offer one word and hold it until it is accepted; returns at a falling edge.
    task automatic send_word(t_in_item w);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        push = 1'b1;
        i_in_item = w;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        if (w.op != OP_UNUSED)
            words_sent++;
    endtask

    task automatic send_op(logic [1:0] op, logic [7:0] data, logic blk);
        t_in_item w;
        w.op           = op;
        w.data_byte    = data;
        w.block_format = blk;
        send_word(w);
    endtask

    // Stop sending and let every expected byte drain out.
    task automatic wait_idle();
        push = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write the mode register while the block is idle.
    task automatic write_mode(bit m);
        wait_idle();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = m;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.set_mode(m);
    endtask

    // Random string byte, weighted toward the escaped characters.
    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = CH_LF;
            1: c = CH_QUOTE;
            2: c = CH_BSLASH;
            3: begin
                case ($urandom_range(0, 3))
                    0: c = CH_BS;
                    1: c = CH_TAB;
                    2: c = CH_FF;
                    default: c = CH_CR;
                endcase
            end
            4, 5: c = 8'($urandom_range(0, 31));
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // One string with random content, sometimes left unclosed.
    task automatic send_string();
        int len;
        len = $urandom_range(0, 10);
        send_op(OP_OPEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat (len) send_op(OP_DATA, rand_char(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) != 0)
            send_op(OP_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Noise: ignored words, stray data and stray closes.
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_op(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            1: send_op(OP_DATA, rand_char(), 1'($urandom_range(0, 1)));
            default: send_op(OP_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        endcase
    endtask

    // Main sequence.
    initial begin
        int phase_end;
        sb = new();
        gaps_on = 1'b1;
        words_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        push = 1'b0;
        i_in_item = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_mode(1'b0);

        // Words before any open, then every escape class with mode none.
        send_op(OP_DATA, 8'h41, 1'b0);
        send_op(OP_CLOSE, 8'hFF, 1'b1);
        send_op(OP_OPEN, 8'h00, 1'b1);
        send_op(OP_DATA, CH_LF, 1'b0);
        send_op(OP_DATA, 8'h00, 1'b1);
        send_op(OP_DATA, 8'h1F, 1'b0);
        send_op(OP_DATA, 8'h0B, 1'b0);
        send_op(OP_DATA, CH_BS, 1'b0);
        send_op(OP_DATA, CH_TAB, 1'b0);
        send_op(OP_DATA, CH_FF, 1'b0);
        send_op(OP_DATA, CH_CR, 1'b0);
        send_op(OP_DATA, CH_QUOTE, 1'b0);
        send_op(OP_DATA, CH_BSLASH, 1'b0);
        send_op(OP_DATA, CH_SPACE, 1'b0);
        send_op(OP_DATA, 8'h7F, 1'b0);
        send_op(OP_DATA, 8'h80, 1'b0);
        send_op(OP_DATA, 8'hFF, 1'b1);
        send_op(OP_UNUSED, 8'hFF, 1'b1);
        send_op(OP_OPEN, 8'hFF, 1'b0);
        send_op(OP_CLOSE, 8'h00, 1'b0);

        // JSON5 mode: block and non-block strings, then a write mid-string.
        write_mode(1'b1);
        send_op(OP_OPEN, 8'h00, 1'b0);
        send_op(OP_DATA, CH_LF, 1'b0);
        send_op(OP_OPEN, 8'h00, 1'b1);
        send_op(OP_DATA, CH_LF, 1'b0);
        write_mode(1'b0);
        send_op(OP_DATA, CH_LF, 1'b0);
        send_op(OP_CLOSE, 8'h00, 1'b0);
        send_op(OP_OPEN, 8'h00, 1'b1);
        send_op(OP_DATA, CH_LF, 1'b0);
        send_op(OP_CLOSE, 8'h00, 1'b0);

        // Random phases, all in JSON5 mode but the second; the last one without gaps.
        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase != 1);
            if (phase == 3)
                gaps_on = 1'b0;
            phase_end = words_sent + RAND_WORDS / 4;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_string();
            end
        end

        // Drain, then give the block time to show any stray output.
        push = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
